// ===== design/bce_pkg.sv =====
// ----------------------------------------------------------------------------
// bce_pkg
// Shared constants, codes and controller/datapath interface types for the
// b-spline curve evaluator.
// ----------------------------------------------------------------------------
package bce_pkg;

  localparam int MAX_POINTS     = 64;
  localparam int MAX_DEGREE     = 7;
  localparam int KNOT_DEPTH     = MAX_POINTS + MAX_DEGREE + 1;
  localparam int SEARCH_ROUNDS  = 16;
  localparam int DIMENSIONS_DEF = 3;

  localparam int IDX_W   = 7;
  localparam int DEG_W   = 3;
  localparam int CNT_W   = 7;
  localparam int Q_W     = 17;
  localparam int C_W     = 32;
  localparam int ROUND_W = 5;
  localparam int DIM_W   = 2;
  localparam int DIV_QW  = 16;

  localparam logic [Q_W-1:0] ONE_Q16 = 17'h10000;

  // item operations
  localparam logic [1:0] OP_WRPT   = 2'd0;
  localparam logic [1:0] OP_WRKNOT = 2'd1;
  localparam logic [1:0] OP_EVAL   = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_DEGREE = 2'd0;
  localparam logic [1:0] REG_COUNT  = 2'd1;
  localparam logic [1:0] REG_MODE   = 2'd2;

  typedef enum logic [1:0] {
    KI_MID  = 2'd0,
    KI_MID1 = 2'd1,
    KI_LO   = 2'd2,
    KI_HI   = 2'd3
  } ksel_t;

  typedef struct packed {
    logic                 accept;
    logic                 span_init;
    logic                 k_fix;
    logic                 span_mid;
    logic                 span_step;
    logic                 set_k_mid;
    logic                 knot_req;
    ksel_t                knot_sel;
    logic                 knot_to_kb;
    logic                 alpha_req;
    logic                 ld_rd;
    logic                 ld_wr;
    logic                 d_rd;
    logic                 mul;
    logic                 add;
    logic                 d_wr;
    logic                 fin_rd;
    logic                 out_load;
    logic [DEG_W-1:0]     j;
    logic [DEG_W-1:0]     r;
    logic [DIM_W-1:0]     dim;
  } bce_cmd_t;

  typedef struct packed {
    logic             too_few;
    logic             u_one;
    logic             u_zero;
    logic             low_gt_high;
    logic             span_hit;
    logic             go_left;
    logic             mid_zero;
    logic             op_done;
    logic [DEG_W-1:0] p;
  } bce_sts_t;

endpackage

// ===== design/bce_div.sv =====
// ----------------------------------------------------------------------------
// bce_div
// Restoring divider, one quotient bit per cycle: q = floor(a * 2^16 / b),
// for a < b.
// ----------------------------------------------------------------------------
module bce_div
  import bce_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [Q_W-1:0]    a,
  input  logic [Q_W-1:0]    b,
  output logic              done,
  output logic [DIV_QW-1:0] q
);

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [3:0]          cnt_r, cnt_nxt;
  logic [Q_W-1:0]      rem_r, rem_nxt;
  logic [Q_W-1:0]      b_r, b_nxt;
  logic [DIV_QW-1:0]   q_r, q_nxt;
  logic [Q_W:0]        trial;
  logic                fits;

  assign trial = {rem_r, 1'b0};
  assign fits  = trial >= {1'b0, b_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    b_nxt    = b_r;
    q_nxt    = q_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = a;
      b_nxt    = b;
    end else if (busy_r) begin
      rem_nxt = fits ? (trial[Q_W-1:0] - b_r) : trial[Q_W-1:0];
      q_nxt   = {q_r[DIV_QW-2:0], fits};
      cnt_nxt = cnt_r + 4'd1;
      if (cnt_r == 4'(DIV_QW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    b_r   <= b_nxt;
    q_r   <= q_nxt;
  end

  assign done = done_r;
  assign q    = q_r;

endmodule

// ===== design/bce_dp.sv =====
// ----------------------------------------------------------------------------
// bce_dp
// Datapath: configuration, point/knot/de boor stores, span search registers,
// knot and alpha generation on the shared divider, blend multiplier.
// ----------------------------------------------------------------------------
module bce_dp
  import bce_pkg::*;
#(
  parameter int DIMENSIONS = DIMENSIONS_DEF
)
(
  input  logic             clk,
  input  logic             rst_n,
  input  bce_cmd_t         cmd,
  output bce_sts_t         sts,
  input  logic [1:0]       in_op,
  input  logic [IDX_W-1:0] in_index,
  input  logic [Q_W-1:0]   in_param,
  input  logic [C_W-1:0]   in_coord_x,
  input  logic [C_W-1:0]   in_coord_y,
  input  logic [C_W-1:0]   in_coord_z,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [CNT_W-1:0] cfg_data,
  output logic [C_W-1:0]   out_x,
  output logic [C_W-1:0]   out_y,
  output logic [C_W-1:0]   out_z,
  output logic             out_status
);

  localparam int LANES_W = DIMENSIONS * C_W;
  localparam int PROD_W  = Q_W + 1 + C_W + 1;
  localparam int DB_D    = MAX_DEGREE + 1;
  localparam int DB_AW   = $clog2(DB_D);
  localparam int PT_AW   = $clog2(MAX_POINTS);

  typedef enum logic [1:0] {
    PD_NONE = 2'd0,
    PD_IMM  = 2'd1,
    PD_MEM  = 2'd2,
    PD_DIV  = 2'd3
  } pend_t;

  typedef enum logic [1:0] {
    TG_KA = 2'd0,
    TG_KB = 2'd1,
    TG_AL = 2'd2
  } tgt_t;

  logic [DEG_W-1:0] degree_r;
  logic [CNT_W-1:0] count_r;
  logic             mode_r;
  logic [CNT_W-1:0] n;
  logic [DEG_W-1:0] p;

  logic [Q_W-1:0]   u_r;
  logic [IDX_W-1:0] low_r, high_r, mid_r, k_r;
  logic [Q_W-1:0]   ka_r, kb_r, alpha_r, imm_r;
  pend_t            pend_r;
  tgt_t             tgt_r;

  logic [Q_W-1:0]   knot_mem [KNOT_DEPTH];
  logic [Q_W-1:0]   knot_rd_r;
  logic [LANES_W-1:0] db_mem [DB_D];
  logic [LANES_W-1:0] rd_a_r, rd_b_r, res_r;
  logic [LANES_W-1:0] pt_rd;
  logic signed [PROD_W-1:0] prod_r;
  logic [C_W-1:0]   out_x_r, out_y_r, out_z_r;
  logic             out_status_r;

  assign n = (count_r > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : count_r;
  assign p = (degree_r > DEG_W'(MAX_DEGREE)) ? DEG_W'(MAX_DEGREE) : degree_r;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      degree_r <= DEG_W'(3);
      count_r  <= CNT_W'(4);
      mode_r   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEGREE: degree_r <= cfg_data[DEG_W-1:0];
        REG_COUNT:  count_r  <= cfg_data;
        REG_MODE:   mode_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // knot index selection
  logic [IDX_W-1:0] ki;
  logic [IDX_W:0]   hi_sum;
  assign hi_sum = {1'b0, k_r} + 8'd1 + {5'd0, cmd.j} - {5'd0, cmd.r};
  always_comb begin
    unique case (cmd.knot_sel)
      KI_MID:  ki = mid_r;
      KI_MID1: ki = mid_r + 7'd1;
      KI_LO:   ki = k_r - {4'd0, p} + {4'd0, cmd.j};
      KI_HI:   ki = hi_sum[IDX_W-1:0];
      default: ki = mid_r;
    endcase
  end

  // alpha operands
  logic signed [Q_W:0] num, den;
  logic [Q_W-1:0]      nmag, dmag;
  assign num  = $signed({1'b0, u_r}) - $signed({1'b0, ka_r});
  assign den  = $signed({1'b0, kb_r}) - $signed({1'b0, ka_r});
  assign nmag = num[Q_W] ? Q_W'(-num) : num[Q_W-1:0];
  assign dmag = den[Q_W] ? Q_W'(-den) : den[Q_W-1:0];

  // request decode: immediate value, knot memory, or divider
  logic             div_start, div_done;
  logic [Q_W-1:0]   div_a, div_b;
  logic [DIV_QW-1:0] div_q;
  pend_t            req_pend;
  logic [Q_W-1:0]   req_imm;

  always_comb begin
    req_pend = PD_NONE;
    req_imm  = '0;
    div_a    = '0;
    div_b    = '0;
    if (cmd.alpha_req) begin
      priority if (den == '0 || num == '0 || num[Q_W] != den[Q_W]) begin
        req_pend = PD_IMM;
      end else if (nmag >= dmag) begin
        req_pend = PD_IMM;
        req_imm  = ONE_Q16;
      end else begin
        req_pend = PD_DIV;
        div_a    = nmag;
        div_b    = dmag;
      end
    end else if (cmd.knot_req) begin
      priority if (mode_r) begin
        req_pend = (ki < IDX_W'(KNOT_DEPTH)) ? PD_MEM : PD_IMM;
      end else if (ki <= {4'd0, p}) begin
        req_pend = PD_IMM;
      end else if (ki >= n) begin
        req_pend = PD_IMM;
        req_imm  = ONE_Q16;
      end else begin
        req_pend = PD_DIV;
        div_a    = Q_W'(ki - {4'd0, p});
        div_b    = Q_W'(n - {4'd0, p});
      end
    end
  end

  assign div_start = (req_pend == PD_DIV);

  bce_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .a     (div_a),
    .b     (div_b),
    .done  (div_done),
    .q     (div_q)
  );

  logic           op_done;
  logic [Q_W-1:0] op_val;
  always_comb begin
    op_done = 1'b0;
    op_val  = imm_r;
    unique case (pend_r)
      PD_IMM: op_done = 1'b1;
      PD_MEM: begin
        op_done = 1'b1;
        op_val  = knot_rd_r;
      end
      PD_DIV: begin
        op_done = div_done;
        op_val  = {1'b0, div_q};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= PD_NONE;
    end else if (req_pend != PD_NONE) begin
      pend_r <= req_pend;
    end else if (op_done) begin
      pend_r <= PD_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (req_pend != PD_NONE) begin
      imm_r <= req_imm;
      tgt_r <= cmd.alpha_req ? TG_AL : (cmd.knot_to_kb ? TG_KB : TG_KA);
    end
    if (op_done) begin
      unique case (tgt_r)
        TG_KA:   ka_r    <= op_val;
        TG_KB:   kb_r    <= op_val;
        TG_AL:   alpha_r <= op_val;
        default: ;
      endcase
    end
  end

  // knot store
  always_ff @(posedge clk) begin
    if (cmd.accept && in_op == OP_WRKNOT && in_index < IDX_W'(KNOT_DEPTH)) begin
      knot_mem[in_index] <= in_param;
    end
    if (cmd.knot_req) begin
      knot_rd_r <= knot_mem[ki];
    end
  end

  // control point stores, one per dimension
  logic [IDX_W-1:0] ld_addr;
  assign ld_addr = k_r - {4'd0, p} + {4'd0, cmd.j};

  for (genvar d = 0; d < DIMENSIONS; d++) begin : g_pt
    logic [C_W-1:0] pt_mem [MAX_POINTS];
    logic [C_W-1:0] pt_rd_r;
    logic [C_W-1:0] wr_val;
    assign wr_val = (d == 0) ? in_coord_x : ((d == 1) ? in_coord_y : in_coord_z);
    always_ff @(posedge clk) begin
      if (cmd.accept && in_op == OP_WRPT && in_index < IDX_W'(MAX_POINTS)) begin
        pt_mem[in_index[PT_AW-1:0]] <= wr_val;
      end
      if (cmd.ld_rd) begin
        pt_rd_r <= pt_mem[ld_addr[PT_AW-1:0]];
      end
    end
    assign pt_rd[d*C_W +: C_W] = pt_rd_r;
  end

  // de boor working store, two registered read ports
  logic [DB_AW-1:0] rd_b_addr;
  assign rd_b_addr = cmd.fin_rd ? DB_AW'(p) : DB_AW'(cmd.j);

  always_ff @(posedge clk) begin
    if (cmd.ld_wr) begin
      db_mem[DB_AW'(cmd.j)] <= pt_rd;
    end else if (cmd.d_wr) begin
      db_mem[DB_AW'(cmd.j)] <= res_r;
    end
    if (cmd.d_rd) begin
      rd_a_r <= db_mem[DB_AW'(cmd.j - 3'd1)];
    end
    if (cmd.d_rd || cmd.fin_rd) begin
      rd_b_r <= db_mem[rd_b_addr];
    end
  end

  // blend: a + floor(alpha * (b - a) / 2^16), one lane per step
  logic signed [C_W-1:0] lane_a, lane_b;
  logic signed [C_W:0]   diff;
  logic [C_W+2:0]        blend;
  assign lane_a = rd_a_r[cmd.dim*C_W +: C_W];
  assign lane_b = rd_b_r[cmd.dim*C_W +: C_W];
  assign diff   = $signed({lane_b[C_W-1], lane_b}) - $signed({lane_a[C_W-1], lane_a});
  assign blend  = {{3{lane_a[C_W-1]}}, lane_a} + prod_r[PROD_W-1:Q_W-1];

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_r <= $signed({1'b0, alpha_r}) * diff;
    end
    if (cmd.add) begin
      res_r[cmd.dim*C_W +: C_W] <= blend[C_W-1:0];
    end
  end

  // span search and evaluate setup
  logic [IDX_W:0] init_sum, mid_sum;
  assign init_sum = {4'd0, p} + {1'b0, n} - 8'd1;
  assign mid_sum  = {1'b0, low_r} + {1'b0, high_r};

  always_ff @(posedge clk) begin
    if (cmd.accept && in_op == OP_EVAL) begin
      u_r <= (in_param > ONE_Q16) ? ONE_Q16 : in_param;
    end
    if (cmd.span_init) begin
      low_r  <= {4'd0, p};
      high_r <= n - 7'd1;
      mid_r  <= init_sum[IDX_W:1];
    end
    if (cmd.k_fix) begin
      k_r <= sts.u_one ? (n - 7'd1) : {4'd0, p};
    end
    if (cmd.span_mid) begin
      mid_r <= mid_sum[IDX_W:1];
    end
    if (cmd.span_step) begin
      if (sts.go_left) begin
        high_r <= mid_r - 7'd1;
      end else begin
        low_r <= mid_r + 7'd1;
      end
    end
    if (cmd.set_k_mid) begin
      k_r <= mid_r;
    end
  end

  assign sts.too_few     = n < ({4'd0, p} + 7'd1);
  assign sts.u_one       = (u_r == ONE_Q16);
  assign sts.u_zero      = (u_r == '0);
  assign sts.low_gt_high = low_r > high_r;
  assign sts.span_hit    = (u_r >= ka_r) && (u_r < kb_r);
  assign sts.go_left     = u_r < ka_r;
  assign sts.mid_zero    = (mid_r == '0);
  assign sts.op_done     = op_done;
  assign sts.p           = p;

  // result register
  logic [3*C_W-1:0] lanes_full;
  assign lanes_full = (3*C_W)'(rd_b_r);

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= sts.too_few;
      out_x_r      <= sts.too_few ? '0 : lanes_full[C_W-1:0];
      out_y_r      <= sts.too_few ? '0 : lanes_full[2*C_W-1:C_W];
      out_z_r      <= sts.too_few ? '0 : lanes_full[3*C_W-1:2*C_W];
    end
  end

  assign out_x      = out_x_r;
  assign out_y      = out_y_r;
  assign out_z      = out_z_r;
  assign out_status = out_status_r;

endmodule

// ===== design/bce_ctrl.sv =====
// ----------------------------------------------------------------------------
// bce_ctrl
// Controller: sequences span search, point load, de boor rounds and the
// result handoff.
// ----------------------------------------------------------------------------
module bce_ctrl
  import bce_pkg::*;
#(
  parameter int DIMENSIONS = DIMENSIONS_DEF
)
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic [1:0] in_op,
  output logic       in_tready,
  input  logic       out_tready,
  output logic       out_tvalid,
  input  bce_sts_t   sts,
  output bce_cmd_t   cmd
);

  typedef enum logic [21:0] {
    ST_IDLE   = 22'h000001,
    ST_START  = 22'h000002,
    ST_SP_CHK = 22'h000004,
    ST_SP_KA  = 22'h000008,
    ST_SP_KAW = 22'h000010,
    ST_SP_KB  = 22'h000020,
    ST_SP_KBW = 22'h000040,
    ST_SP_DEC = 22'h000080,
    ST_LD_RD  = 22'h000100,
    ST_LD_WR  = 22'h000200,
    ST_BL_KA  = 22'h000400,
    ST_BL_KAW = 22'h000800,
    ST_BL_KB  = 22'h001000,
    ST_BL_KBW = 22'h002000,
    ST_BL_AL  = 22'h004000,
    ST_BL_ALW = 22'h008000,
    ST_BL_RD  = 22'h010000,
    ST_BL_MUL = 22'h020000,
    ST_BL_ADD = 22'h040000,
    ST_BL_WR  = 22'h080000,
    ST_FIN    = 22'h100000,
    ST_DONE   = 22'h200000
  } state_t;

  state_t               state_r, state_nxt;
  logic [DEG_W-1:0]     j_r, j_nxt, r_r, r_nxt;
  logic [DIM_W-1:0]     dim_r, dim_nxt;
  logic [ROUND_W-1:0]   round_r, round_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 accept;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    j_nxt     = j_r;
    r_nxt     = r_r;
    dim_nxt   = dim_r;
    round_nxt = round_r;
    cmd       = '0;
    cmd.accept = accept;
    cmd.j      = j_r;
    cmd.r      = r_r;
    cmd.dim    = dim_r;
    cmd.knot_sel = KI_MID;
    out_valid_nxt = out_valid_r && !out_tready;

    unique case (state_r)
      ST_IDLE: begin
        if (accept && in_op == OP_EVAL) state_nxt = ST_START;
      end
      ST_START: begin
        priority if (sts.too_few) begin
          state_nxt = ST_DONE;
        end else if (sts.u_one || sts.u_zero) begin
          cmd.k_fix = 1'b1;
          j_nxt     = '0;
          state_nxt = ST_LD_RD;
        end else begin
          cmd.span_init = 1'b1;
          round_nxt     = '0;
          state_nxt     = ST_SP_CHK;
        end
      end
      ST_SP_CHK: begin
        if (round_r == ROUND_W'(SEARCH_ROUNDS) || sts.low_gt_high) begin
          cmd.set_k_mid = 1'b1;
          j_nxt         = '0;
          state_nxt     = ST_LD_RD;
        end else begin
          cmd.span_mid = 1'b1;
          state_nxt    = ST_SP_KA;
        end
      end
      ST_SP_KA: begin
        cmd.knot_req = 1'b1;
        cmd.knot_sel = KI_MID;
        state_nxt    = ST_SP_KAW;
      end
      ST_SP_KAW: begin
        if (sts.op_done) state_nxt = ST_SP_KB;
      end
      ST_SP_KB: begin
        cmd.knot_req   = 1'b1;
        cmd.knot_sel   = KI_MID1;
        cmd.knot_to_kb = 1'b1;
        state_nxt      = ST_SP_KBW;
      end
      ST_SP_KBW: begin
        if (sts.op_done) state_nxt = ST_SP_DEC;
      end
      ST_SP_DEC: begin
        if (sts.span_hit || (sts.go_left && sts.mid_zero)) begin
          cmd.set_k_mid = 1'b1;
          j_nxt         = '0;
          state_nxt     = ST_LD_RD;
        end else begin
          cmd.span_step = 1'b1;
          round_nxt     = round_r + 5'd1;
          state_nxt     = ST_SP_CHK;
        end
      end
      ST_LD_RD: begin
        cmd.ld_rd = 1'b1;
        state_nxt = ST_LD_WR;
      end
      ST_LD_WR: begin
        cmd.ld_wr = 1'b1;
        if (j_r == sts.p) begin
          if (sts.p == '0) begin
            state_nxt = ST_FIN;
          end else begin
            r_nxt     = 3'd1;
            j_nxt     = sts.p;
            state_nxt = ST_BL_KA;
          end
        end else begin
          j_nxt     = j_r + 3'd1;
          state_nxt = ST_LD_RD;
        end
      end
      ST_BL_KA: begin
        cmd.knot_req = 1'b1;
        cmd.knot_sel = KI_LO;
        state_nxt    = ST_BL_KAW;
      end
      ST_BL_KAW: begin
        if (sts.op_done) state_nxt = ST_BL_KB;
      end
      ST_BL_KB: begin
        cmd.knot_req   = 1'b1;
        cmd.knot_sel   = KI_HI;
        cmd.knot_to_kb = 1'b1;
        state_nxt      = ST_BL_KBW;
      end
      ST_BL_KBW: begin
        if (sts.op_done) state_nxt = ST_BL_AL;
      end
      ST_BL_AL: begin
        cmd.alpha_req = 1'b1;
        state_nxt     = ST_BL_ALW;
      end
      ST_BL_ALW: begin
        if (sts.op_done) state_nxt = ST_BL_RD;
      end
      ST_BL_RD: begin
        cmd.d_rd  = 1'b1;
        dim_nxt   = '0;
        state_nxt = ST_BL_MUL;
      end
      ST_BL_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_BL_ADD;
      end
      ST_BL_ADD: begin
        cmd.add = 1'b1;
        if (dim_r == DIM_W'(DIMENSIONS - 1)) begin
          state_nxt = ST_BL_WR;
        end else begin
          dim_nxt   = dim_r + 2'd1;
          state_nxt = ST_BL_MUL;
        end
      end
      ST_BL_WR: begin
        cmd.d_wr = 1'b1;
        if (j_r == r_r) begin
          if (r_r == sts.p) begin
            state_nxt = ST_FIN;
          end else begin
            r_nxt     = r_r + 3'd1;
            j_nxt     = sts.p;
            state_nxt = ST_BL_KA;
          end
        end else begin
          j_nxt     = j_r - 3'd1;
          state_nxt = ST_BL_KA;
        end
      end
      ST_FIN: begin
        cmd.fin_rd = 1'b1;
        state_nxt  = ST_DONE;
      end
      ST_DONE: begin
        // hold until the result register is free
        if (!out_valid_r || out_tready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      j_r         <= '0;
      r_r         <= '0;
      dim_r       <= '0;
      round_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      j_r         <= j_nxt;
      r_r         <= r_nxt;
      dim_r       <= dim_nxt;
      round_r     <= round_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

// ===== design/bspline_curve_evaluator_core.sv =====
// ----------------------------------------------------------------------------
// bspline_curve_evaluator_core
// De boor evaluation of a 3-d b-spline curve in fixed point, with loadable
// control points and knots.
// ----------------------------------------------------------------------------
//  channel | dir | handshake            | payload
//  in_     | in  | in_tvalid/in_tready  | in_tdata: op, index, u/knot, x, y, z
//  out_    | out | out_tvalid/out_tready| out_tdata: x, y, z, status
//  cfg_    | in  | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
//  point and knot writes are taken from idle; evaluate runs the span search,
//  point load and de boor rounds, with knots and alphas computed on the
//  shared divider.
//  reset is synchronous; stores hold garbage until written.
//  a finished result waits in the output register; the next item is taken
//  while it waits.
// ----------------------------------------------------------------------------
module bspline_curve_evaluator_core
  import bce_pkg::*;
#(
  parameter int DIMENSIONS = DIMENSIONS_DEF
)
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // operation, index, param_value, coord_x, coord_y, coord_z
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata,  // point_x, point_y, point_z, status
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [6:0]   cfg_data
);

  bce_cmd_t       cmd;
  bce_sts_t       sts;
  logic [C_W-1:0] px, py, pz;
  logic           pstat;

  assign cfg_ready = 1'b1;

  bce_ctrl #(.DIMENSIONS(DIMENSIONS)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_op      (in_tdata[1:0]),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .sts        (sts),
    .cmd        (cmd)
  );

  bce_dp #(.DIMENSIONS(DIMENSIONS)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_op      (in_tdata[1:0]),
    .in_index   (in_tdata[8:2]),
    .in_param   (in_tdata[25:9]),
    .in_coord_x (in_tdata[57:26]),
    .in_coord_y (in_tdata[89:58]),
    .in_coord_z (in_tdata[121:90]),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_x      (px),
    .out_y      (py),
    .out_z      (pz),
    .out_status (pstat)
  );

  assign out_tdata = {7'd0, pstat, pz, py, px};

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[96] |-> out_tdata[95:0] == '0)
    else $error("error status with nonzero point");

  a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tdata[1:0] == OP_EVAL |=> !in_tready)
    else $error("input taken during evaluation");

  a_out_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result without evaluation");

endmodule

// ===== sim/tb_bspline_curve_evaluator_core.sv =====
// ----------------------------------------------------------------------------
// tb_bspline_curve_evaluator_core
// Self-checking bench for the b-spline curve evaluator: loads points and
// knots, evaluates over several degree/count/knot-mode settings with random
// idling on both streams, and checks every curve point against a predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

typedef struct {
  logic [31:0] px;
  logic [31:0] py;
  logic [31:0] pz;
  logic        status;
} curve_point_t;

class curve_scoreboard;
  int unsigned  deg_reg;
  int unsigned  cnt_reg;
  int unsigned  mode_reg;
  int           xs[64];
  int           ys[64];
  int           zs[64];
  longint       knots[72];
  curve_point_t pending[$];
  int           errors;

  function new();
    deg_reg = 3;
    cnt_reg = 4;
    mode_reg = 0;
    errors = 0;
  endfunction

  function void set_reg(logic [1:0] idx, logic [6:0] val);
    if (idx == bce_pkg::REG_DEGREE) deg_reg = val[2:0];
    else if (idx == bce_pkg::REG_COUNT) cnt_reg = val;
    else if (idx == bce_pkg::REG_MODE) mode_reg = val[0];
  endfunction

  function longint knot_val(int i, int n, int p);
    if (mode_reg != 0) return (i < 72) ? knots[i] : 0;
    if (i <= p) return 0;
    if (i >= n) return 65536;
    return (longint'(i - p) * 65536) / longint'(n - p);
  endfunction

  function int span_of(longint u, int n, int p);
    int lo_i, hi_i, mid;
    lo_i = p;
    hi_i = n - 1;
    mid = (p + n - 1) / 2;
    if (u >= 65536) return n - 1;
    if (u <= 0) return p;
    for (int r = 0; r < 16; r++) begin
      if (lo_i > hi_i) break;
      mid = (lo_i + hi_i) / 2;
      if (u >= knot_val(mid, n, p) && u < knot_val(mid + 1, n, p)) break;
      if (u < knot_val(mid, n, p)) begin
        if (mid == 0) break;
        hi_i = mid - 1;
      end else begin
        lo_i = mid + 1;
      end
    end
    return mid;
  endfunction

  function longint floor_q16(longint v);
    longint q;
    q = v / 65536;
    if ((v % 65536) != 0 && v < 0) q -= 1;
    return q;
  endfunction

  function void note_item(logic [127:0] d);
    logic [1:0]   op;
    int           idx, n, p, k;
    longint       u, lo_k, hi_k, den, alpha;
    longint       acc[8][3];
    curve_point_t res;
    op = d[1:0];
    idx = d[8:2];
    u = d[25:9];
    if (op == bce_pkg::OP_WRPT) begin
      if (idx < 64) begin
        xs[idx] = d[57:26];
        ys[idx] = d[89:58];
        zs[idx] = d[121:90];
      end
      return;
    end
    if (op == bce_pkg::OP_WRKNOT) begin
      if (idx < 72) knots[idx] = u;
      return;
    end
    if (op != bce_pkg::OP_EVAL) return;
    n = (cnt_reg > 64) ? 64 : cnt_reg;
    p = (deg_reg > 7) ? 7 : deg_reg;
    res = '{32'd0, 32'd0, 32'd0, 1'b1};
    if (n >= p + 1) begin
      if (u > 65536) u = 65536;
      k = span_of(u, n, p);
      for (int j = 0; j <= p; j++) begin
        acc[j][0] = xs[k - p + j];
        acc[j][1] = ys[k - p + j];
        acc[j][2] = zs[k - p + j];
      end
      for (int r = 1; r <= p; r++) begin
        for (int j = p; j >= r; j--) begin
          lo_k = knot_val(k - p + j, n, p);
          hi_k = knot_val(k + 1 + j - r, n, p);
          den = hi_k - lo_k;
          alpha = 0;
          if (den != 0) alpha = ((u - lo_k) * 65536) / den;
          if (alpha < 0) alpha = 0;
          if (alpha > 65536) alpha = 65536;
          for (int c = 0; c < 3; c++)
            acc[j][c] = floor_q16((65536 - alpha) * acc[j-1][c] + alpha * acc[j][c]);
        end
      end
      res = '{acc[p][0][31:0], acc[p][1][31:0], acc[p][2][31:0], 1'b0};
    end
    pending = {pending, res};
  endfunction

  function void check_point(logic [103:0] d);
    curve_point_t e;
    if (pending.size() == 0) begin
      $error("unexpected result beat %h", d);
      errors++;
      return;
    end
    e = pending.pop_front();
    if (d[31:0] !== e.px) begin
      $error("point_x expected %h actual %h", e.px, d[31:0]); errors++;
    end
    if (d[63:32] !== e.py) begin
      $error("point_y expected %h actual %h", e.py, d[63:32]); errors++;
    end
    if (d[95:64] !== e.pz) begin
      $error("point_z expected %h actual %h", e.pz, d[95:64]); errors++;
    end
    if (d[96] !== e.status) begin
      $error("status expected %0d actual %0d", e.status, d[96]); errors++;
    end
  endfunction
endclass

module tb_bspline_curve_evaluator_core;
  import bce_pkg::*;

  localparam longint CYCLE_LIMIT = 20000000;
  // operation code with no meaning, must be ignored
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [127:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [103:0] out_tdata;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [1:0]   cfg_index = '0;
  logic [6:0]   cfg_data = '0;

  curve_scoreboard sb = new();
  int     send_idle = 0;
  int     recv_stall = 0;
  longint cycles = 0;

  bspline_curve_evaluator_core dut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_bspline_curve_evaluator_core: errors");
      $finish;
    end
  end

  // result side: check accepted beats, stall at random
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_point(out_tdata);
    out_tready <= ($urandom_range(99) >= recv_stall);
  end

  function automatic logic [127:0] item(logic [1:0] op, logic [6:0] idx, logic [16:0] u,
                                        logic [31:0] x, logic [31:0] y, logic [31:0] z);
    return {6'd0, z, y, x, u, idx, op};
  endfunction

  task automatic send(logic [127:0] d);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= d;
    do @(posedge clk); while (!in_tready);
    sb.note_item(d);
  endtask

  // valid stays high across back-to-back writes; caller drops it
  task automatic write_reg(logic [1:0] idx, logic [6:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [16:0] rand_u();
    case ($urandom_range(9))
      0: return 17'd0;
      1: return ONE_Q16;
      2: return 17'($urandom_range(131071, 65537));
      default: return 17'($urandom_range(65536));
    endcase
  endfunction

  task automatic load_knots(int p, int n, bit ordered);
    int unsigned vals[];
    vals = new[72];
    foreach (vals[i]) vals[i] = ordered ? $urandom_range(65536) : $urandom_range(131071);
    if (ordered) begin
      vals.sort();
      foreach (vals[i]) begin
        if (i <= p) vals[i] = 0;
        if (i >= n) vals[i] = 65536;
      end
    end
    foreach (vals[i]) send(item(OP_WRKNOT, 7'(i), 17'(vals[i]), '0, '0, '0));
  endtask

  int deg_set[8]  = '{3, 1, 7, 7, 0, 2, 5, 4};
  int cnt_set[8]  = '{4, 2, 64, 5, 10, 127, 33, 64};
  int mode_set[8] = '{0, 0, 1, 0, 0, 1, 1, 0};

  initial begin
    int sel;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // every point once so no evaluation reads an unwritten entry
    for (int i = 0; i < 64; i++)
      send(item(OP_WRPT, 7'(i), '0, $urandom, $urandom, $urandom));
    load_knots(3, 4, 1'b1);

    // directed corners at reset settings
    send(item(OP_WRPT, 7'd0, '0, 32'h7fffffff, 32'h80000000, 32'hffffffff));
    send(item(OP_WRPT, 7'd3, '0, 32'h80000000, 32'h7fffffff, 32'h00000001));
    send(item(OP_EVAL, 7'd127, 17'd0, '1, '1, '1));
    send(item(OP_EVAL, 7'd0, ONE_Q16, '0, '0, '0));
    send(item(OP_EVAL, 7'd0, 17'h1ffff, '0, '0, '0));
    send(item(OP_EVAL, 7'd0, 17'd1, '0, '0, '0));
    send(item(OP_EVAL, 7'd0, 17'hffff, '0, '0, '0));
    send(item(OP_EVAL, 7'd0, 17'h8000, '0, '0, '0));
    send(item(OP_UNUSED, 7'd5, 17'h1ffff, '1, '1, '1));
    send(item(OP_WRPT, 7'd64, '0, 32'h12345678, '1, '0));
    send(item(OP_WRPT, 7'd127, '0, '1, '1, '1));
    send(item(OP_WRKNOT, 7'd72, 17'h1ffff, '0, '0, '0));
    send(item(OP_WRKNOT, 7'd127, 17'h1ffff, '0, '0, '0));
    send(item(OP_WRKNOT, 7'd71, 17'h1ffff, '0, '0, '0));
    send(item(OP_EVAL, 7'd0, 17'h4000, '0, '0, '0));
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 59; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 59; end
        default: begin send_idle = 6; recv_stall = 6; end
      endcase
      write_reg(REG_DEGREE, 7'(deg_set[ph]));
      write_reg(REG_COUNT, 7'(cnt_set[ph]));
      write_reg(REG_MODE, 7'(mode_set[ph]));
      cfg_valid <= 1'b0;
      if (mode_set[ph] != 0) load_knots(deg_set[ph], cnt_set[ph], ph != 5);
      for (int i = 0; i < 55; i++) begin
        sel = $urandom_range(99);
        if (sel < 70)
          send(item(OP_EVAL, 7'($urandom), rand_u(), $urandom, $urandom, $urandom));
        else if (sel < 88)
          send(item(OP_WRPT, 7'($urandom_range(63)), 17'($urandom), $urandom, $urandom,
                    $urandom));
        else if (sel < 92)
          send(item(OP_WRKNOT, 7'($urandom_range(71)),
                    (ph == 5) ? 17'($urandom_range(131071)) : 17'($urandom_range(65536)),
                    $urandom, $urandom, $urandom));
        else if (sel < 96)
          send(item(2'($urandom_range(1)), 7'($urandom_range(127, 72)), 17'($urandom),
                    $urandom, $urandom, $urandom));
        else
          send(item(OP_UNUSED, 7'($urandom), 17'($urandom), $urandom, $urandom, $urandom));
      end
      drain();
    end

    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("tb_bspline_curve_evaluator_core: clean");
    else
      $display("tb_bspline_curve_evaluator_core: errors");
    $finish;
  end
endmodule
